// ===== rtl/core/jsu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg - shared types for the json string unescaper
// transfer payloads of both channels and the run record passed from the
// decoder front end to the output back end
// ----------------------------------------------------------------------------
package jsu_pkg;

    // most bytes one input transfer can produce, plus headroom
    localparam int MaxRun  = 8;
    localparam int RunLenW = $clog2(MaxRun + 1);
    localparam int RunIdxW = $clog2(MaxRun);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_has_byte;
        logic       out_run_end;
        logic       out_string_end;
    } out_item_t;

    // decoded bytes of one input transfer, byte 0 goes out first
    typedef struct packed {
        logic [MaxRun-1:0][7:0] data;
        logic [RunLenW-1:0]     len;
        logic                   last;
    } run_t;

endpackage : jsu_pkg
`default_nettype wire

// ===== rtl/core/jsu_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front - escape decoder front end
// takes one string byte per transfer, tracks escape state and builds the run
// of utf-8 bytes that the byte produces
// ----------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire in_item_t in_item,
    input  wire logic     queue_full,
    output logic          push,
    output run_t          push_run
);

    typedef enum logic [2:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_HEX,
        MODE_HIWAIT,
        MODE_HIESC,
        MODE_LOHEX
    } mode_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } piece_t;

    localparam logic [7:0]  CharBs    = 8'h5C;
    localparam logic [7:0]  CharU     = 8'h75;
    localparam logic [7:0]  CharN     = 8'h6E;
    localparam logic [7:0]  CharR     = 8'h72;
    localparam logic [7:0]  CharT     = 8'h74;
    localparam logic [7:0]  CharB     = 8'h62;
    localparam logic [7:0]  CharF     = 8'h66;
    localparam logic [5:0]  HighTag   = 6'b110110;
    localparam logic [5:0]  LowTag    = 6'b110111;
    localparam logic [20:0] CpReplace = 21'h00FFFD;
    localparam logic [20:0] CpSuppBase = 21'h010000;

    // returns {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

    function automatic piece_t utf8_piece(input logic [20:0] cp);
        piece_t p;
        p = '0;
        if (cp < 21'h000080) begin
            p.b[0] = cp[7:0];
            p.len  = 3'd1;
        end else if (cp < 21'h000800) begin
            p.b[0] = {3'b110, cp[10:6]};
            p.b[1] = {2'b10, cp[5:0]};
            p.len  = 3'd2;
        end else if (cp < 21'h010000) begin
            p.b[0] = {4'b1110, cp[15:12]};
            p.b[1] = {2'b10, cp[11:6]};
            p.b[2] = {2'b10, cp[5:0]};
            p.len  = 3'd3;
        end else begin
            p.b[0] = {5'b11110, cp[20:18]};
            p.b[1] = {2'b10, cp[17:12]};
            p.b[2] = {2'b10, cp[11:6]};
            p.b[3] = {2'b10, cp[5:0]};
            p.len  = 3'd4;
        end
        return p;
    endfunction

    function automatic run_t append(input run_t r, input piece_t p);
        run_t               o;
        logic [RunLenW-1:0] off;
        o = r;
        for (int k = 0; k < MaxRun; k++) begin
            off = RunLenW'(k) - r.len;
            if (RunLenW'(k) >= r.len && off < RunLenW'(p.len)) begin
                o.data[k] = p.b[off[1:0]];
            end
        end
        o.len = r.len + RunLenW'(p.len);
        return o;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [1:0]  count_reg, count_next;
    logic [11:0] accum_reg, accum_next;
    logic [9:0]  high_reg, high_next;
    logic [7:0]  held_reg  [3];
    logic [7:0]  held_next [3];

    logic        accept;
    logic [7:0]  cur;
    logic [4:0]  hex;
    logic [15:0] code;
    logic        act_text, act_esc, act_take, act_pair;
    logic        pre_fffd, emit_held, fin_fffd;
    logic        main_on, main_raw;
    logic [7:0]  raw_byte;
    logic [20:0] main_cp;
    piece_t      p_fffd, p_held_old, p_main, p_tail;
    run_t        run;

    assign accept = in_valid && !queue_full;
    assign cur    = in_item.in_byte;
    assign hex    = hex_digit(cur);
    assign code   = {accum_reg, hex[3:0]};

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        accum_next = accum_reg;
        high_next  = high_reg;
        for (int i = 0; i < 3; i++) begin
            held_next[i] = held_reg[i];
        end
        act_text  = 1'b0;
        act_esc   = 1'b0;
        act_take  = 1'b0;
        act_pair  = 1'b0;
        pre_fffd  = 1'b0;
        emit_held = 1'b0;
        fin_fffd  = 1'b0;
        main_on   = 1'b0;
        main_raw  = 1'b0;
        raw_byte  = cur;
        main_cp   = '0;
        p_tail    = '0;

        // first step: what the current mode does with the byte
        unique case (mode_reg)
            MODE_TEXT: act_text = 1'b1;
            MODE_ESC:  act_esc  = 1'b1;
            MODE_HEX:
            begin
                if (!hex[4]) begin
                    emit_held = 1'b1;
                    act_text  = 1'b1;
                end else if (count_reg != 2'd3) begin
                    held_next[count_reg] = cur;
                    count_next           = count_reg + 2'd1;
                    accum_next           = {accum_reg[7:0], hex[3:0]};
                end else begin
                    act_take = 1'b1;
                end
            end
            MODE_HIWAIT:
            begin
                if (cur == CharBs) begin
                    mode_next = MODE_HIESC;
                end else begin
                    pre_fffd = 1'b1;
                    act_text = 1'b1;
                end
            end
            MODE_HIESC:
            begin
                if (cur == CharU) begin
                    mode_next  = MODE_LOHEX;
                    count_next = 2'd0;
                    accum_next = '0;
                end else begin
                    pre_fffd = 1'b1;
                    act_esc  = 1'b1;
                end
            end
            MODE_LOHEX:
            begin
                if (!hex[4]) begin
                    pre_fffd  = 1'b1;
                    emit_held = 1'b1;
                    act_text  = 1'b1;
                end else if (count_reg != 2'd3) begin
                    held_next[count_reg] = cur;
                    count_next           = count_reg + 2'd1;
                    accum_next           = {accum_reg[7:0], hex[3:0]};
                end else if (code[15:10] == LowTag) begin
                    act_pair = 1'b1;
                end else begin
                    pre_fffd = 1'b1;
                    act_take = 1'b1;
                end
            end
            default: act_text = 1'b1;
        endcase

        // second step: shared text, escape and code point handling
        if (act_text) begin
            if (cur == CharBs) begin
                mode_next = MODE_ESC;
            end else begin
                mode_next = MODE_TEXT;
                main_on   = 1'b1;
                main_raw  = 1'b1;
            end
        end
        if (act_esc) begin
            mode_next = MODE_TEXT;
            main_on   = 1'b1;
            main_raw  = 1'b1;
            unique case (cur)
                CharN: raw_byte = 8'h0A;
                CharR: raw_byte = 8'h0D;
                CharT: raw_byte = 8'h09;
                CharB: raw_byte = 8'h08;
                CharF: raw_byte = 8'h0C;
                CharU:
                begin
                    main_on    = 1'b0;
                    mode_next  = MODE_HEX;
                    count_next = 2'd0;
                    accum_next = '0;
                end
                default: raw_byte = cur;
            endcase
        end
        if (act_take) begin
            mode_next = MODE_TEXT;
            if (code[15:10] == HighTag) begin
                high_next = code[9:0];
                mode_next = MODE_HIWAIT;
            end else if (code[15:10] == LowTag) begin
                main_on = 1'b1;
                main_cp = CpReplace;
            end else begin
                main_on = 1'b1;
                main_cp = {5'b0, code};
            end
        end
        if (act_pair) begin
            mode_next = MODE_TEXT;
            main_on   = 1'b1;
            main_cp   = CpSuppBase + {1'b0, high_reg, code[9:0]};
        end

        // end of string flushes whatever is pending
        if (in_item.in_last) begin
            unique case (mode_next)
                MODE_ESC:
                begin
                    p_tail.b[0] = CharBs;
                    p_tail.len  = 3'd1;
                end
                MODE_HEX:
                begin
                    for (int i = 0; i < 3; i++) begin
                        p_tail.b[i] = held_next[i];
                    end
                    p_tail.len = {1'b0, count_next};
                end
                MODE_HIWAIT: fin_fffd = 1'b1;
                MODE_HIESC:
                begin
                    fin_fffd    = 1'b1;
                    p_tail.b[0] = CharBs;
                    p_tail.len  = 3'd1;
                end
                MODE_LOHEX:
                begin
                    fin_fffd = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        p_tail.b[i] = held_next[i];
                    end
                    p_tail.len = {1'b0, count_next};
                end
                default: ;
            endcase
            mode_next = MODE_TEXT;
        end
    end

    always_comb
    begin
        p_fffd     = utf8_piece(CpReplace);
        p_held_old = '0;
        for (int i = 0; i < 3; i++) begin
            p_held_old.b[i] = held_reg[i];
        end
        p_held_old.len = emit_held ? {1'b0, count_reg} : 3'd0;
        if (!main_on) begin
            p_main = '0;
        end else if (main_raw) begin
            p_main      = '0;
            p_main.b[0] = raw_byte;
            p_main.len  = 3'd1;
        end else begin
            p_main = utf8_piece(main_cp);
        end

        run      = '0;
        run      = append(run, pre_fffd ? p_fffd : piece_t'('0));
        run      = append(run, p_held_old);
        run      = append(run, p_main);
        run      = append(run, fin_fffd ? p_fffd : piece_t'('0));
        run      = append(run, p_tail);
        run.last = in_item.in_last;
    end

    assign push     = accept && (run.len != '0 || in_item.in_last);
    assign push_run = run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_TEXT;
            count_reg <= '0;
            accum_reg <= '0;
            high_reg  <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            accum_reg <= accum_next;
            high_reg  <= high_next;
        end
    end

    // held digit bytes are only read below the digit count
    always_ff @(posedge clk)
    begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                held_reg[i] <= held_next[i];
            end
        end
    end

endmodule : jsu_front
`default_nettype wire

// ===== rtl/core/jsu_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_queue - run queue
// small fifo of decoded runs between the front end and the back end
// ----------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire run_t push_run,
    input  wire logic pop,
    output logic      full,
    output logic      not_empty,
    output run_t      head
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    run_t            mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CntW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CntW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_run;
        end
    end

endmodule : jsu_queue
`default_nettype wire

// ===== rtl/core/jsu_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back - output serialiser
// sends the bytes of the head run one per transfer through an output register
// ----------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic head_valid,
    input  wire run_t head,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output out_item_t out_item
);

    logic [RunIdxW-1:0] idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;
    logic               load;
    logic               has_byte;
    logic               run_end;

    assign load     = head_valid && (!out_valid_reg || !out_stall);
    assign has_byte = (head.len != '0);
    assign run_end  = !has_byte || ({1'b0, idx_reg} + RunLenW'(1) == head.len);
    assign pop      = load && run_end;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        if (load) begin
            out_valid_next               = 1'b1;
            out_item_next.out_byte       = has_byte ? head.data[idx_reg] : 8'h00;
            out_item_next.out_has_byte   = has_byte;
            out_item_next.out_run_end    = run_end;
            out_item_next.out_string_end = run_end && head.last;
            idx_next                     = run_end ? '0 : idx_reg + RunIdxW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule : jsu_back
`default_nettype wire

// ===== rtl/core/json_string_unescape_utf8_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top - json string body to utf-8 unescaper
// decodes simple and \uXXXX escapes of a json string body into utf-8 bytes
// ----------------------------------------------------------------------------
// The block takes one byte of a json string body per input transfer, with
// in_last on the final byte, and returns the unescaped text as utf-8 bytes,
// one per output transfer. The front end decodes a byte in the cycle it is
// accepted and writes the whole run it produces (zero to seven bytes) into a
// run queue of QUEUE_DEPTH entries; the back end then sends that run one byte
// per cycle while out_stall is low, through an output register. An input byte
// is taken every cycle while the queue has room, so with no output stall the
// sustained rate is one input per cycle for plain text, and an input that
// expands to k output bytes takes k output transfers (a \u escape that
// completes to a supplementary code point gives four). Every run closes with
// out_run_end; the run of the final byte also carries out_string_end, and a
// final byte that produces nothing gives one bare end marker with out_has_byte
// low. The decoder returns to plain text after each string.
module json_string_unescape_utf8_top
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_item,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_item
);

    // front end to queue
    logic push;
    run_t push_run;
    logic queue_full;

    // queue to back end
    logic head_valid;
    run_t head;
    logic pop;

    // the input side stalls only while the run queue is full
    assign in_stall = queue_full;

    // decoder: escape state machine and run builder
    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .queue_full (queue_full),
        .push       (push),
        .push_run   (push_run)
    );

    // decouples the decoder from the byte serialiser
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_run  (push_run),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (head_valid),
        .head      (head)
    );

    // one output transfer per byte of the head run, or a bare marker for an empty run
    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

`ifndef NO_ASSERTIONS
    // no input transfer produces more bytes than a run can hold
    a_run_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_run.len < RunLenW'(MaxRun))
        else $error("run longer than expected");

    // the queue is never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("run queue overflow");

    // a bare marker only ever closes a string
    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.out_has_byte |->
            out_item.out_string_end && out_item.out_run_end && out_item.out_byte == 8'h00)
        else $error("bare marker outside string end");

    // string end is always also a run end
    a_string_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_string_end |-> out_item.out_run_end)
        else $error("string end without run end");
`endif

endmodule : json_string_unescape_utf8_top
`default_nettype wire
